// ===== rtl/core/h2s_pkg.sv =====
// shared types, constants and the root-factor function for the pixel converter
package h2s_pkg;

  localparam int ROOT_SHIFT = 30;
  localparam int ROOT_COUNT = 25;
  localparam logic [15:0] SRGB_INV_EXP = 16'd1707;
  localparam logic [31:0] ALPHA_SCALE = 32'd65536;
  localparam logic [8:0] LIN_MUL = 9'd323;
  localparam logic [7:0] SRGB_MUL = 8'd211;
  localparam logic [4:0] DIV_BY = 5'd25;
  localparam logic [27:0] DIV_RECIP = 28'd171798691;

  typedef enum logic [1:0] {
    CFG_EXPOSURE_SCALE,
    CFG_USE_CUSTOM_GAMMA,
    CFG_INVERSE_GAMMA,
    CFG_IGNORE_ALPHA
  } cfg_index_e;

  typedef struct packed {
    logic [31:0] exposure_scale;
    logic        use_custom_gamma;
    logic [15:0] inverse_gamma;
    logic        ignore_alpha;
  } cfg_t;

  // q30 value of 2^(-2^-k)
  function automatic logic [29:0] root_q30(input int k);
    longint unsigned r;
    longint unsigned v;
    longint unsigned b;
    longint unsigned res;
    int j;
    int s;
    r = 64'd1 << (ROOT_SHIFT - 1);
    for (j = 1; j <= k; j++) begin
      v = r << ROOT_SHIFT;
      res = 64'd0;
      b = 64'd1 << 62;
      for (s = 0; s < 32; s++) begin
        if (b > v) b = b >> 2;
      end
      for (s = 0; s < 32; s++) begin
        if (b != 64'd0) begin
          if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
          end else begin
            res = res >> 1;
          end
          b = b >> 2;
        end
      end
      r = res;
    end
    return r[29:0];
  endfunction

endpackage

// ===== rtl/core/h2s_if.sv =====
// stream interfaces for input pixels and output bytes
interface h2s_pix_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_half;
  logic [15:0] green_half;
  logic [15:0] blue_half;
  logic [15:0] alpha_half;
  modport source(output valid, red_half, green_half, blue_half, alpha_half, input ready);
  modport sink(input valid, red_half, green_half, blue_half, alpha_half, output ready);
endinterface

interface h2s_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_byte;
  logic [7:0] green_byte;
  logic [7:0] blue_byte;
  logic [7:0] alpha_byte;
  modport source(output valid, red_byte, green_byte, blue_byte, alpha_byte, input ready);
  modport sink(input valid, red_byte, green_byte, blue_byte, alpha_byte, output ready);
endinterface

// ===== rtl/core/h2s_half_fix.sv =====
// two-stage half-float to clamped fixed-point fraction
module h2s_half_fix import h2s_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     adv,
  input  logic [15:0]              half,
  input  logic [31:0]              scale,
  output logic [FRACTION_BITS:0]   x
);
  localparam int F = FRACTION_BITS;
  localparam int PW = 43;
  localparam int SW = PW + 29;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic        pos_inf;
  logic        kill;
  logic [10:0] sig;
  logic [4:0]  eeff;
  logic [PW-1:0] prod;
  logic [4:0]  eeff_q;
  logic        pos_inf_q;
  logic        kill_q;
  logic [SW-1:0] wide;

  always_comb begin
    pos_inf = (half[14:10] == 5'h1F) && (half[9:0] == 10'd0) && !half[15];
    kill = (half[14:10] == 5'h1F) ? !pos_inf : half[15];
    sig = (half[14:10] != 5'd0) ? {1'b1, half[9:0]} : {1'b0, half[9:0]};
    eeff = (half[14:10] != 5'd0) ? half[14:10] : 5'd1;
    wide = (SW'(prod) << (eeff_q - 5'd1)) >> (40 - F);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= PW'(sig) * PW'(scale);
      eeff_q <= eeff;
      pos_inf_q <= pos_inf;
      kill_q <= kill;
      if (pos_inf_q) begin
        x <= ONE;
      end else if (kill_q) begin
        x <= '0;
      end else if (wide > SW'(ONE)) begin
        x <= ONE;
      end else begin
        x <= wide[F:0];
      end
    end
  end

endmodule

// ===== rtl/core/h2s_pow.sv =====
// pipelined x^g: normalize, one squaring per stage, scale, one root factor per stage
module h2s_pow import h2s_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   adv,
  input  logic [FRACTION_BITS:0] x_in,
  input  logic [15:0]            g,
  output logic [FRACTION_BITS:0] y,
  output logic [FRACTION_BITS:0] x_out
);
  localparam int F = FRACTION_BITS;
  localparam int MW = F + 1;
  localparam int KW = $clog2(F + 1);
  localparam int NW = F + KW;
  localparam int TW = NW + 4;
  localparam int IW = TW - F;
  localparam int AW = ROOT_SHIFT + 1;
  localparam logic [MW-1:0] ONE = {1'b1, {F{1'b0}}};

  logic [KW-1:0] lead;
  logic [KW-1:0] kk;
  logic [MW-1:0] mnorm;

  logic [MW-1:0] m_q [0:F];
  logic [F-1:0]  fr_q [0:F];
  logic [KW-1:0] kk_q [0:F];
  logic          lz_q [0:F];
  logic [MW-1:0] lx_q [0:F];

  logic [AW-1:0] acc_q [0:F];
  logic [F-1:0]  r_q [0:F];
  logic [IW-1:0] i_q [0:F];
  logic          ez_q [0:F];
  logic [MW-1:0] ex_q [0:F];

  logic [NW-1:0]    n_val;
  logic [NW+15:0]   t_prod;
  logic [MW-1:0]    res;

  always_comb begin
    lead = '0;
    for (int b = 0; b <= F; b++) begin
      if (x_in[b]) lead = KW'(b);
    end
    kk = KW'(F) - lead;
    mnorm = x_in << kk;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_q[0] <= mnorm;
      fr_q[0] <= '0;
      kk_q[0] <= kk;
      lz_q[0] <= (x_in == '0);
      lx_q[0] <= x_in;
    end
  end

  for (genvar i = 0; i < F; i++) begin : g_sq
    logic [2*MW-1:0] sq;
    logic [MW:0]     sh;
    logic [MW-1:0]   m_next;
    logic            bit_next;
    always_comb begin
      sq = (2*MW)'(m_q[i]) * (2*MW)'(m_q[i]);
      sh = sq[F+MW:F];
      bit_next = sh[F+1];
      m_next = bit_next ? sh[F+1:1] : sh[F:0];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        m_q[i+1] <= m_next;
        fr_q[i+1] <= {fr_q[i][F-2:0], bit_next};
        kk_q[i+1] <= kk_q[i];
        lz_q[i+1] <= lz_q[i];
        lx_q[i+1] <= lx_q[i];
      end
    end
  end

  always_comb begin
    n_val = {kk_q[F], {F{1'b0}}} - NW'(fr_q[F]);
    t_prod = (NW+16)'(n_val) * (NW+16)'(g);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_q[0] <= AW'(1) << ROOT_SHIFT;
      r_q[0] <= t_prod[F+11:12];
      i_q[0] <= t_prod[NW+15:F+12];
      ez_q[0] <= lz_q[F];
      ex_q[0] <= lx_q[F];
    end
  end

  for (genvar k = 1; k <= F; k++) begin : g_exp
    localparam logic [ROOT_SHIFT-1:0] RK = root_q30(k);
    logic [AW+ROOT_SHIFT-1:0] pk;
    always_comb begin
      pk = (AW+ROOT_SHIFT)'(acc_q[k-1]) * (AW+ROOT_SHIFT)'(RK);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        acc_q[k] <= r_q[k-1][F-k] ? pk[AW+ROOT_SHIFT-1:ROOT_SHIFT] : acc_q[k-1];
        r_q[k] <= r_q[k-1];
        i_q[k] <= i_q[k-1];
        ez_q[k] <= ez_q[k-1];
        ex_q[k] <= ex_q[k-1];
      end
    end
  end

  always_comb begin
    res = acc_q[F][ROOT_SHIFT:ROOT_SHIFT-F];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_out <= ex_q[F];
      if (ez_q[F]) begin
        y <= (g == 16'd0) ? ONE : '0;
      end else if (i_q[F] > IW'(F)) begin
        y <= '0;
      end else begin
        y <= res >> i_q[F];
      end
    end
  end

endmodule

// ===== rtl/core/h2s_encode.sv =====
// four-stage curve select, divide by 25, offset and byte scaling
module h2s_encode import h2s_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   adv,
  input  cfg_t                   cfg,
  input  logic [FRACTION_BITS:0] x,
  input  logic [FRACTION_BITS:0] a,
  output logic [7:0]             byte_out
);
  localparam int F = FRACTION_BITS;
  localparam int MW = F + 1;
  localparam int VW = F + 5;
  localparam int AW = F + 8;
  localparam int PW = VW + 28;
  localparam logic [MW-1:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic [MW-1:0] THRESH = MW'((64'd31308 << F) / 64'd10000000);
  localparam logic [MW-1:0] OFFSET = MW'((64'd55 << F) / 64'd1000);

  logic          lin;
  logic [VW-1:0] v_lin;
  logic [AW-1:0] v_srgb;
  logic [VW-1:0] v_q;
  logic [MW-1:0] a_q;
  logic          lin_q;
  logic [PW-1:0] p2;
  logic [MW-1:0] q0_q;
  logic [VW-1:0] v_q2;
  logic [MW-1:0] a_q2;
  logic          lin_q2;
  logic [VW-1:0] rem;
  logic [MW-1:0] q;
  logic [MW-1:0] yv;
  logic [MW-1:0] y_q;
  logic [MW+7:0] bp;

  always_comb begin
    lin = (x <= THRESH);
    v_lin = VW'(x) * VW'(LIN_MUL);
    v_srgb = AW'(a) * AW'(SRGB_MUL);
    p2 = PW'(v_q) * PW'(DIV_RECIP);
    rem = v_q2 - VW'(q0_q) * VW'(DIV_BY);
    q = (rem >= VW'(DIV_BY)) ? q0_q + MW'(1) : q0_q;
    if (cfg.use_custom_gamma) begin
      yv = a_q2;
    end else if (lin_q2) begin
      yv = q;
    end else begin
      yv = (q > OFFSET) ? q - OFFSET : '0;
    end
    if (yv > ONE) yv = ONE;
    bp = (MW+8)'(y_q) * (MW+8)'(8'hFF);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_q <= lin ? v_lin : v_srgb[AW-1:3];
      a_q <= a;
      lin_q <= lin;
      q0_q <= p2[PW-1:32];
      v_q2 <= v_q;
      a_q2 <= a_q;
      lin_q2 <= lin_q;
      y_q <= yv;
      byte_out <= bp[F+7:F];
    end
  end

endmodule

// ===== rtl/core/hdr_pixel_to_srgb8.sv =====
// top level: half-float rgba pixel to srgb 8-bit rgba converter
//
// pix_in carries one pixel per transaction as four half-float bit patterns;
// pix_out carries the four converted bytes. both use valid/ready.
// config is written via cfg_wr_en/cfg_index/cfg_wr_data, one register per
// cycle; the user must write only while no pixel is in flight (unenforced).
// the datapath is a fixed pipeline of 2*FRACTION_BITS+9 stages (41 at the
// default): two for half decoding, one normalize stage, one squaring stage
// per log bit, one exponent-scale stage, one root-multiply stage per bit,
// one shift stage and four encode stages.
// a pixel is taken every cycle the skid is empty; results keep input order.
// a one-entry skid buffer after the last stage holds a result when the
// receiver stalls; while it is full the whole pipeline holds and pix_in
// ready is low, so nothing is dropped or duplicated.
// reset clears all valid bits and the skid, and loads register defaults:
// exposure 1.0, srgb curve, inverse gamma 1.0, alpha converted.
module hdr_pixel_to_srgb8 import h2s_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  h2s_pix_in_if.sink    pix_in,
  h2s_pix_out_if.source pix_out,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_wr_data
);
  localparam int F = FRACTION_BITS;
  localparam int LAT = 2 * F + 9;
  localparam int ADL = 2 * F + 6;

  cfg_t cfg;
  logic adv;
  logic valid_q [0:LAT-1];
  logic skid_v;
  logic [7:0] skid_r, skid_g, skid_b, skid_a;

  logic [15:0] g_sel;
  logic [F:0]  xh [0:2];
  logic [F:0]  yp [0:2];
  logic [F:0]  xp [0:2];
  logic [7:0]  lane_byte [0:2];
  logic [15:0] lane_half [0:2];
  logic [F:0]  xa;
  logic [F:0]  ad_q [0:ADL-1];
  logic [F+8:0] abp;
  logic [7:0]  alpha_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exposure_scale <= 32'd65536;
      cfg.use_custom_gamma <= 1'b0;
      cfg.inverse_gamma <= 16'd4096;
      cfg.ignore_alpha <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_e'(cfg_index))
        CFG_EXPOSURE_SCALE:   cfg.exposure_scale <= cfg_wr_data;
        CFG_USE_CUSTOM_GAMMA: cfg.use_custom_gamma <= cfg_wr_data[0];
        CFG_INVERSE_GAMMA:    cfg.inverse_gamma <= cfg_wr_data[15:0];
        CFG_IGNORE_ALPHA:     cfg.ignore_alpha <= cfg_wr_data[0];
      endcase
    end
  end

  assign adv = !skid_v;
  assign pix_in.ready = adv;
  assign g_sel = cfg.use_custom_gamma ? cfg.inverse_gamma : SRGB_INV_EXP;
  assign lane_half[0] = pix_in.red_half;
  assign lane_half[1] = pix_in.green_half;
  assign lane_half[2] = pix_in.blue_half;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    h2s_half_fix #(.FRACTION_BITS(F)) u_half (
      .clk(clk), .adv(adv), .half(lane_half[c]), .scale(cfg.exposure_scale), .x(xh[c])
    );
    h2s_pow #(.FRACTION_BITS(F)) u_pow (
      .clk(clk), .adv(adv), .x_in(xh[c]), .g(g_sel), .y(yp[c]), .x_out(xp[c])
    );
    h2s_encode #(.FRACTION_BITS(F)) u_enc (
      .clk(clk), .adv(adv), .cfg(cfg), .x(xp[c]), .a(yp[c]), .byte_out(lane_byte[c])
    );
  end

  h2s_half_fix #(.FRACTION_BITS(F)) u_alpha (
    .clk(clk), .adv(adv), .half(pix_in.alpha_half), .scale(ALPHA_SCALE), .x(xa)
  );

  assign abp = (F+9)'(ad_q[ADL-1]) * (F+9)'(8'hFF);

  always_ff @(posedge clk) begin
    if (adv) begin
      ad_q[0] <= xa;
      for (int j = 1; j < ADL; j++) ad_q[j] <= ad_q[j-1];
      alpha_q <= cfg.ignore_alpha ? 8'hFF : abp[F+7:F];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < LAT; j++) valid_q[j] <= 1'b0;
    end else if (adv) begin
      valid_q[0] <= pix_in.valid;
      for (int j = 1; j < LAT; j++) valid_q[j] <= valid_q[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (pix_out.ready) skid_v <= 1'b0;
    end else if (valid_q[LAT-1] && !pix_out.ready) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v) begin
      skid_r <= lane_byte[0];
      skid_g <= lane_byte[1];
      skid_b <= lane_byte[2];
      skid_a <= alpha_q;
    end
  end

  assign pix_out.valid = skid_v || valid_q[LAT-1];
  assign pix_out.red_byte = skid_v ? skid_r : lane_byte[0];
  assign pix_out.green_byte = skid_v ? skid_g : lane_byte[1];
  assign pix_out.blue_byte = skid_v ? skid_b : lane_byte[2];
  assign pix_out.alpha_byte = skid_v ? skid_a : alpha_q;

  a_skid_load: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(valid_q[LAT-1] && !pix_out.ready))
    else $error("skid loaded without a stalled result");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_v && pix_out.ready |=> !skid_v)
    else $error("skid not drained after transaction");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> valid_q[0])
    else $error("accepted pixel missing from first stage");

endmodule

// ===== sim/hdr_pixel_to_srgb8_tb.sv =====
// testbench for the half-float rgba to srgb 8-bit pixel converter
module hdr_pixel_to_srgb8_tb;
  import h2s_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam longint unsigned LIN_KNEE = (64'd31308 << FRAC) / 64'd10000000;
  localparam longint unsigned SRGB_OFS = (64'd55 << FRAC) / 64'd1000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic [15:0] a;
  } half_pix_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } byte_pix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wr_data = '0;

  h2s_pix_in_if pix_in ();
  h2s_pix_out_if pix_out ();

  hdr_pixel_to_srgb8 dut (
    .clk(clk), .rst(rst), .pix_in(pix_in.sink), .pix_out(pix_out.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  // model copy of the registers
  logic [31:0] m_exposure = 32'd65536;
  logic m_custom = 1'b0;
  logic [15:0] m_inv_gamma = 16'd4096;
  logic m_ignore_alpha = 1'b0;
  longint unsigned root_q [ROOT_COUNT];

  half_pix_t pending_pix [$];
  byte_pix_t expected_bytes [$];
  int errors = 0;
  int pixels_in = 0;
  int pixels_out = 0;
  bit no_idle = 1'b0;
  int hold_off = 0;
  bit hold_done = 1'b0;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned half_to_lin(input logic [15:0] h,
                                                  input longint unsigned scale);
    longint unsigned sig;
    longint unsigned prod;
    longint unsigned v;
    int e;
    int sh;
    e = h[14:10];
    if (e == 31) return (h[9:0] == 0 && !h[15]) ? ONE : 0;
    if (h[15]) return 0;
    sig = (e != 0) ? {53'd0, 1'b1, h[9:0]} : {54'd0, h[9:0]};
    sh = ((e != 0) ? e : 1) - 25 - 16 + FRAC;
    prod = sig * scale;
    v = (sh >= 0) ? (prod << sh) : (prod >> (-sh));
    return (v > ONE) ? ONE : v;
  endfunction

  function automatic longint unsigned neg_log2(input longint unsigned x);
    int p;
    longint unsigned m;
    longint unsigned frac;
    p = FRAC;
    frac = 0;
    while (p > 0 && x[p] == 1'b0) p--;
    m = x << (FRAC - p);
    for (int i = 0; i < FRAC; i++) begin
      m = (m * m) >> FRAC;
      frac = frac << 1;
      if (m >= 2 * ONE) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(FRAC - p) * ONE - frac;
  endfunction

  function automatic longint unsigned pow_q(input longint unsigned x,
                                            input longint unsigned g);
    longint unsigned t;
    longint unsigned ip;
    longint unsigned acc;
    if (x == 0) return (g == 0) ? ONE : 0;
    t = (neg_log2(x) * g) >> 12;
    ip = t >> FRAC;
    if (ip > FRAC) return 0;
    acc = 64'd1 << ROOT_SHIFT;
    for (int k = 1; k <= FRAC; k++) begin
      if (t[FRAC - k]) acc = (acc * root_q[k]) >> ROOT_SHIFT;
    end
    return (acc >> (ROOT_SHIFT - FRAC)) >> ip;
  endfunction

  function automatic logic [7:0] frac_to_byte(input longint unsigned y);
    longint unsigned b;
    b = (y * 255) >> FRAC;
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  function automatic logic [7:0] encode_color(input logic [15:0] h);
    longint unsigned x;
    longint unsigned y;
    longint unsigned a;
    x = half_to_lin(h, m_exposure);
    if (m_custom) begin
      y = pow_q(x, m_inv_gamma);
    end else if (x <= LIN_KNEE) begin
      y = (x * 1292) / 100;
    end else begin
      a = (pow_q(x, SRGB_INV_EXP) * 1055) / 1000;
      y = (a > SRGB_OFS) ? a - SRGB_OFS : 0;
    end
    if (y > ONE) y = ONE;
    return frac_to_byte(y);
  endfunction

  function automatic byte_pix_t convert_pixel(input half_pix_t p);
    byte_pix_t o;
    o.r = encode_color(p.r);
    o.g = encode_color(p.g);
    o.b = encode_color(p.b);
    o.a = m_ignore_alpha ? 8'd255 : frac_to_byte(half_to_lin(p.a, 64'd65536));
    return o;
  endfunction

  function automatic logic [15:0] rand_half();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: return 16'($urandom);
      3: begin
        case ($urandom_range(0, 4))
          0: return 16'h7C00;
          1: return 16'hFC00;
          2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 5'h1F, 10'($urandom_range(1, 1023))};
          3: return {1'b0, 5'd0, 10'($urandom)};
          default: return 16'h8000 | 16'($urandom);
        endcase
      end
      default: return {1'b0, 5'($urandom_range(0, 15)), 10'($urandom)};
    endcase
  endfunction

  // sender
  always @(posedge clk) begin
    logic nv;
    half_pix_t np;
    nv = pix_in.valid;
    np = {pix_in.red_half, pix_in.green_half, pix_in.blue_half, pix_in.alpha_half};
    if (rst) begin
      nv = 1'b0;
    end else if (!pix_in.valid || pix_in.ready) begin
      nv = 1'b0;
      if (pending_pix.size() > 0 && (no_idle || $urandom_range(0, 99) >= 30)) begin
        np = pending_pix.pop_front();
        nv = 1'b1;
      end
    end
    pix_in.valid <= nv;
    {pix_in.red_half, pix_in.green_half, pix_in.blue_half, pix_in.alpha_half} <= np;
  end

  // receiver, with one long hold-off once traffic is going
  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pix_out.ready <= 1'b0;
    end else if (!hold_done && pixels_in >= 300) begin
      hold_done <= 1'b1;
      hold_off <= 200;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= no_idle || ($urandom_range(0, 99) >= 30);
    end
  end

  // monitor
  always @(posedge clk) begin
    byte_pix_t got;
    byte_pix_t want;
    if (!rst && pix_in.valid && pix_in.ready) begin
      expected_bytes.push_back(convert_pixel({pix_in.red_half, pix_in.green_half,
                                              pix_in.blue_half, pix_in.alpha_half}));
      pixels_in++;
    end
    if (!rst && pix_out.valid && pix_out.ready) begin
      got = {pix_out.red_byte, pix_out.green_byte, pix_out.blue_byte, pix_out.alpha_byte};
      pixels_out++;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output transaction %h", got);
      end else begin
        want = expected_bytes.pop_front();
        if (got.r !== want.r || got.g !== want.g || got.b !== want.b || got.a !== want.a) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected r=%0d g=%0d b=%0d a=%0d got r=%0d g=%0d b=%0d a=%0d",
                     want.r, want.g, want.b, want.a, got.r, got.g, got.b, got.a);
        end
      end
    end
  end

  task automatic write_reg(input cfg_index_e idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_EXPOSURE_SCALE: m_exposure = val;
      CFG_USE_CUSTOM_GAMMA: m_custom = val[0];
      CFG_INVERSE_GAMMA: m_inv_gamma = val[15:0];
      CFG_IGNORE_ALPHA: m_ignore_alpha = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] expo, input logic cust,
                            input logic [15:0] invg, input logic ign);
    write_reg(CFG_EXPOSURE_SCALE, expo);
    write_reg(CFG_USE_CUSTOM_GAMMA, {31'd0, cust});
    write_reg(CFG_INVERSE_GAMMA, {16'd0, invg});
    write_reg(CFG_IGNORE_ALPHA, {31'd0, ign});
  endtask

  task automatic drain();
    while (pending_pix.size() > 0 || pix_in.valid || expected_bytes.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_phase(input int count);
    logic [15:0] edges [12] = '{16'h0000, 16'h3C00, 16'h7C00, 16'hFC00, 16'h7E00,
                                 16'h8000, 16'h0001, 16'h03FF, 16'h7BFF, 16'h1A6B,
                                 16'h3800, 16'hBC00};
    for (int i = 0; i < 12; i++)
      pending_pix.push_back({edges[i], edges[(i + 3) % 12], edges[(i + 7) % 12],
                             edges[(i + 5) % 12]});
    pending_pix.push_back({16'hFFFF, 16'h7C01, 16'h3BFF, 16'h3C01});
    for (int i = 0; i < count; i++)
      pending_pix.push_back({rand_half(), rand_half(), rand_half(), rand_half()});
  endtask

  initial begin
    root_q[0] = 64'd1 << (ROOT_SHIFT - 1);
    for (int k = 1; k < ROOT_COUNT; k++) root_q[k] = int_sqrt(root_q[k - 1] << ROOT_SHIFT);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    load_phase(220);
    drain();
    set_config(32'd0, 1'b0, 16'd4096, 1'b1);
    load_phase(220);
    drain();
    set_config(32'hFFFF_FFFF, 1'b1, 16'd0, 1'b0);
    load_phase(200);
    drain();
    set_config(32'd65536, 1'b1, 16'hFFFF, 1'b1);
    no_idle = 1'b1;
    load_phase(200);
    drain();
    no_idle = 1'b0;
    set_config($urandom_range(1 << 12, 1 << 19), 1'b1, 16'($urandom_range(1000, 12000)), 1'b0);
    load_phase(150);
    drain();
    set_config($urandom, 1'b0, 16'($urandom), 1'b0);
    load_phase(150);
    drain();

    if (expected_bytes.size() != 0) errors++;
    $display("%0d pixels converted over six register settings (srgb and power curves,", pixels_out);
    $display("exposure extremes, alpha forced and converted, one long output stall)");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== hdr_pixel_to_srgb8.f =====
rtl/core/h2s_pkg.sv
rtl/core/h2s_if.sv
rtl/core/h2s_half_fix.sv
rtl/core/h2s_pow.sv
rtl/core/h2s_encode.sv
rtl/core/hdr_pixel_to_srgb8.sv
sim/hdr_pixel_to_srgb8_tb.sv
